// ===== src/llla_pkg.sv =====
// types and codes shared by the least-loaded link allocator
package llla_pkg;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOFIT   = 3'd1;
    localparam logic [2:0] ST_MISSING = 3'd2;
    localparam logic [2:0] ST_UNDER   = 3'd3;
    localparam logic [2:0] ST_IGNORED = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  iface;
        logic [31:0] amount;
        logic [7:0]  content_id;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  chosen_iface;
        logic [31:0] used_after;
    } t_rsp;

endpackage

// ===== src/llla_ram.sv =====
// generic single-write, single-read ram with registered read data
module llla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/least_loaded_link_allocator_core.sv =====
// least-loaded link allocator: link and reservation tables in rams, one request at a time
// one item in flight; an alloc scans the link ram one slot a cycle through its read port
// with one cross-multiply comparator, and no new item is accepted until the alloc is done
// the result register lets the next item be accepted while a result waits to be taken
// after reset the reservation ram is cleared slot by slot with input ready low
module least_loaded_link_allocator_core
    import llla_pkg::*;
#(
    parameter int LINKS        = 8,
    parameter int RESERVATIONS = 256,
    parameter int BW_BITS      = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out
);

    localparam int LW  = (LINKS > 1) ? $clog2(LINKS) : 1;
    localparam int LN  = 2 ** LW;
    localparam int XLW = (LW > 3) ? LW : 3;
    localparam int RW  = $clog2(RESERVATIONS);
    localparam int XRW = (RW > 8) ? RW : 8;
    localparam int LWW = 2 * BW_BITS;
    localparam int RWW = 1 + LW + BW_BITS;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ADD   = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_AWR   = 3'd4;
    localparam logic [2:0] S_FREE1 = 3'd5;
    localparam logic [2:0] S_FREE2 = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]         r_state, n_state;
    logic [RW-1:0]      r_clr, n_clr;
    logic [LN-1:0]      r_lvalid, n_lvalid;
    logic [LW-1:0]      r_idx, n_idx;
    logic               r_found, n_found;
    logic [LW-1:0]      r_best, n_best;
    logic [BW_BITS-1:0] r_bneed, n_bneed;
    logic [BW_BITS-1:0] r_bcap, n_bcap;
    t_req               r_req, n_req;
    logic [RW-1:0]      r_cidx, n_cidx;
    t_rsp               r_res, n_res;
    logic               r_ovalid, n_ovalid;
    t_rsp               r_out, n_out;

    logic               l_we;
    logic [LW-1:0]      l_waddr, l_raddr;
    logic [LWW-1:0]     l_wdata, l_rdata;
    logic               v_we;
    logic [RW-1:0]      v_waddr, v_raddr;
    logic [RWW-1:0]     v_wdata, v_rdata;

    logic               accept;
    logic [XLW-1:0]     in_iface_x, rq_iface_x;
    logic [XRW-1:0]     in_cid_x;
    logic               in_cid_ok, rq_slot_ok;
    logic [LW-1:0]      rq_slot;
    logic [RW-1:0]      in_cidx;
    logic [BW_BITS-1:0] amt;
    logic [BW_BITS-1:0] l_cap, l_used;
    logic               v_valid;
    logic [LW-1:0]      v_link;
    logic [BW_BITS-1:0] v_amt;
    logic [BW_BITS:0]   need;
    logic               fits, better;
    logic [LWW-1:0]     prod_new, prod_best;

    llla_ram #(.WIDTH(LWW), .DEPTH(LINKS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

    llla_ram #(.WIDTH(RWW), .DEPTH(RESERVATIONS)) u_resv_ram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wdata (v_wdata),
        .i_raddr (v_raddr),
        .o_rdata (v_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    assign in_iface_x = XLW'(i_in.iface);
    assign in_cid_x   = XRW'(i_in.content_id);
    assign in_cid_ok  = ({1'b0, in_cid_x} < (XRW + 1)'(RESERVATIONS));
    assign in_cidx    = in_cid_x[RW-1:0];
    assign rq_iface_x = XLW'(r_req.iface);
    assign rq_slot_ok = ({1'b0, rq_iface_x} < (XLW + 1)'(LINKS));
    assign rq_slot    = rq_iface_x[LW-1:0];
    assign amt        = BW_BITS'(r_req.amount);

    assign l_cap   = l_rdata[LWW-1:BW_BITS];
    assign l_used  = l_rdata[BW_BITS-1:0];
    assign v_valid = v_rdata[RWW-1];
    assign v_link  = v_rdata[BW_BITS +: LW];
    assign v_amt   = v_rdata[BW_BITS-1:0];

    // scan comparator: candidate load need/cap against the best so far
    assign need      = {1'b0, l_used} + {1'b0, amt};
    assign fits      = r_lvalid[r_idx] && (need <= {1'b0, l_cap});
    assign prod_new  = LWW'(need[BW_BITS-1:0]) * LWW'(r_bcap);
    assign prod_best = LWW'(r_bneed) * LWW'(l_cap);
    assign better    = !r_found || (prod_new < prod_best);

    assign v_raddr = accept ? in_cidx : r_cidx;

    always_comb begin
        case (r_state)
            S_IDLE:  l_raddr = (i_in.opcode == OP_ALLOC) ? '0 : in_iface_x[LW-1:0];
            S_SCAN:  l_raddr = r_idx + 1'b1;
            S_FREE1: l_raddr = v_link;
            default: l_raddr = r_idx;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_lvalid = r_lvalid;
        n_idx    = r_idx;
        n_found  = r_found;
        n_best   = r_best;
        n_bneed  = r_bneed;
        n_bcap   = r_bcap;
        n_req    = r_req;
        n_cidx   = r_cidx;
        n_res    = r_res;
        n_ovalid = r_ovalid && !i_out_ready;
        n_out    = r_out;
        l_we     = 1'b0;
        l_waddr  = rq_slot;
        l_wdata  = '0;
        v_we     = 1'b0;
        v_waddr  = r_cidx;
        v_wdata  = '0;

        case (r_state)
            S_CLEAR: begin
                v_we    = 1'b1;
                v_waddr = r_clr;
                n_clr   = r_clr + 1'b1;
                if (r_clr == RW'(RESERVATIONS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_req   = i_in;
                    n_cidx  = in_cidx;
                    n_idx   = '0;
                    n_found = 1'b0;
                    if (i_in.opcode == OP_ADD) begin
                        n_state = S_ADD;
                    end else if (i_in.opcode == OP_NONE) begin
                        n_res   = '{status: ST_IGNORED, chosen_iface: '0, used_after: '0};
                        n_state = S_OUT;
                    end else if (!in_cid_ok) begin
                        n_res   = '{status: ST_MISSING, chosen_iface: '0, used_after: '0};
                        n_state = S_OUT;
                    end else if (i_in.opcode == OP_ALLOC) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_FREE1;
                    end
                end
            end
            S_ADD: begin
                n_state = S_OUT;
                if (!rq_slot_ok) begin
                    n_res = '{status: ST_IGNORED, chosen_iface: r_req.iface, used_after: '0};
                end else if (r_lvalid[rq_slot]) begin
                    n_res = '{status: ST_IGNORED, chosen_iface: r_req.iface,
                              used_after: 32'(l_used)};
                end else if (amt == '0) begin
                    n_res = '{status: ST_IGNORED, chosen_iface: r_req.iface, used_after: '0};
                end else begin
                    l_we              = 1'b1;
                    l_waddr           = rq_slot;
                    l_wdata           = {amt, {BW_BITS{1'b0}}};
                    n_lvalid[rq_slot] = 1'b1;
                    n_res = '{status: ST_OK, chosen_iface: r_req.iface, used_after: '0};
                end
            end
            S_SCAN: begin
                if (fits && better) begin
                    n_found = 1'b1;
                    n_best  = r_idx;
                    n_bneed = need[BW_BITS-1:0];
                    n_bcap  = l_cap;
                end
                n_idx = r_idx + 1'b1;
                if (r_idx == LW'(LINKS - 1)) begin
                    n_state = S_AWR;
                end
            end
            S_AWR: begin
                n_state = S_OUT;
                if (!r_found) begin
                    n_res = '{status: ST_NOFIT, chosen_iface: '0, used_after: '0};
                end else begin
                    l_we    = 1'b1;
                    l_waddr = r_best;
                    l_wdata = {r_bcap, r_bneed};
                    if (!v_valid) begin
                        v_we    = 1'b1;
                        v_wdata = {1'b1, r_best, amt};
                    end
                    n_res = '{status: ST_OK, chosen_iface: 3'(r_best),
                              used_after: 32'(r_bneed)};
                end
            end
            S_FREE1: begin
                if (!v_valid) begin
                    n_res   = '{status: ST_MISSING, chosen_iface: '0, used_after: '0};
                    n_state = S_OUT;
                end else begin
                    n_state = S_FREE2;
                end
            end
            S_FREE2: begin
                n_state = S_OUT;
                if (!r_lvalid[v_link]) begin
                    n_res = '{status: ST_UNDER, chosen_iface: '0, used_after: '0};
                end else if (l_used < v_amt) begin
                    n_res = '{status: ST_UNDER, chosen_iface: 3'(v_link),
                              used_after: 32'(l_used)};
                end else begin
                    l_we    = 1'b1;
                    l_waddr = v_link;
                    l_wdata = {l_cap, l_used - v_amt};
                    v_we    = 1'b1;
                    v_wdata = '0;
                    n_res = '{status: ST_OK, chosen_iface: 3'(v_link),
                              used_after: 32'(l_used - v_amt)};
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    n_out    = r_res;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_lvalid <= '0;
            r_idx    <= '0;
            r_found  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_lvalid <= n_lvalid;
            r_idx    <= n_idx;
            r_found  <= n_found;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best  <= n_best;
        r_bneed <= n_bneed;
        r_bcap  <= n_bcap;
        r_req   <= n_req;
        r_cidx  <= n_cidx;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

endmodule
